>>> rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// Binding potential evaluator package
// Shared fixed-point formats, constants and register codes.
// ----------------------------------------------------------------------------
package bpe_pkg;

   // default payload format, signed Q16.16
   localparam int BPE_DATA_WIDTH = 32;
   localparam int BPE_FRAC_BITS  = 16;

   // internal formats: ratio s in Q.28, exponential sum in Q.30
   localparam int S_FRAC = 28;
   localparam int M_FRAC = 30;

   // log2(e) in Q.28 and ln(2) in Q.30
   localparam int                LOG2E_W   = 29;
   localparam logic [LOG2E_W-1:0] LOG2E_Q28 = 29'd387270501;
   localparam int                LN2_W     = 30;
   localparam logic [LN2_W-1:0]   LN2_Q30   = 30'd744261118;

   // ratio range: positive side ends at 2^7, negative side at 2^6
   localparam int LIMIT_LOG2 = 7;
   localparam int Q_BITS     = S_FRAC + LIMIT_LOG2;

   // exponential series length and per-term formats
   localparam int TAYLOR_TERMS = 12;
   localparam int TERM_W       = M_FRAC + 1;
   localparam int G_W          = M_FRAC;
   localparam int RECIP_SHIFT  = 32;

   // partial product chunk of the wide multipliers
   localparam int MUL_CHUNK = 32;

   // signed exponent width
   localparam int K_W = 10;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_DEPTH_SCALE     = 2'd0;
   localparam logic [1:0] REG_DECAY_LENGTH    = 2'd1;
   localparam logic [1:0] REG_REST_SEPARATION = 2'd2;

endpackage

>>> rtl/bpe_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of the ratio divider: takes one dividend bit, yields
// one quotient bit, hands remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module bpe_div_cell
   import bpe_pkg::*;
#(
   parameter int DW  = BPE_DATA_WIDTH,
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic [DW-2:0]     divisor,
   input  logic [DW:0]       dividend_mag,
   input  logic [DW-2:0]     src_rem,
   input  logic [Q_BITS-1:0] src_quot,
   output logic [DW-2:0]     dst_rem,
   output logic [Q_BITS-1:0] dst_quot
);

   logic              nbit;
   logic [DW-1:0]     trial;
   logic              fits;
   logic [DW-2:0]     rem_ff, rem_in;
   logic [Q_BITS-1:0] quot_ff, quot_in;

   // pick the dividend bit of this step (dividend is magnitude shifted up)
   generate
      if (IDX >= S_FRAC) begin : g_bit
         assign nbit = dividend_mag[IDX-S_FRAC];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
   endgenerate

   // compare and subtract
   always_comb begin
      trial   = {src_rem, nbit};
      fits    = trial >= {1'b0, divisor};
      rem_in  = fits ? (DW-1)'(trial - {1'b0, divisor}) : trial[DW-2:0];
      quot_in = {src_quot[Q_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign dst_rem  = rem_ff;
   assign dst_quot = quot_ff;

endmodule

>>> rtl/bpe_wide_mul.sv
// ----------------------------------------------------------------------------
// Wide multiplier
// Unsigned product in two stages: chunked partial products, then their sum.
// ----------------------------------------------------------------------------
module bpe_wide_mul
   import bpe_pkg::*;
#(
   parameter int AW = 64,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic [AW-1:0]    src_a,
   input  logic [BW-1:0]    src_b,
   output logic [AW+BW-1:0] dst_p
);

   localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int APW = NA * MUL_CHUNK;
   localparam int BPW = NB * MUL_CHUNK;
   localparam int SW  = APW + BPW;
   localparam int PPW = 2 * MUL_CHUNK;

   logic [APW-1:0] a_pad;
   logic [BPW-1:0] b_pad;
   logic [PPW-1:0] pp_ff [NA][NB];
   logic [PPW-1:0] pp_in [NA][NB];
   logic [SW-1:0]  sum_in;
   logic [AW+BW-1:0] prod_ff;

   // form the partial products
   always_comb begin
      a_pad = APW'(src_a);
      b_pad = BPW'(src_b);
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = PPW'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                        * PPW'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
         end
      end
   end

   // add the aligned partial products
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (SW'(pp_ff[i][j]) << (MUL_CHUNK * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      pp_ff   <= pp_in;
      prod_ff <= sum_in[AW+BW-1:0];
   end

   assign dst_p = prod_ff;

endmodule

>>> rtl/bpe_taylor_cell.sv
// ----------------------------------------------------------------------------
// Series cell
// One term of the exponential series: term = ((term * g) >> 30) / N,
// added to the running sum, over three stages.
// ----------------------------------------------------------------------------
module bpe_taylor_cell
   import bpe_pkg::*;
#(
   parameter int N = 1
) (
   input  logic              clock,
   input  logic [G_W-1:0]    src_g,
   input  logic [TERM_W-1:0] src_term,
   input  logic [TERM_W-1:0] src_sum,
   output logic [G_W-1:0]    dst_g,
   output logic [TERM_W-1:0] dst_term,
   output logic [TERM_W-1:0] dst_sum
);

   localparam int              RW    = RECIP_SHIFT + 1;
   localparam logic [RW-1:0]   RECIP = RW'((64'd1 << RECIP_SHIFT) / N);
   localparam int              NW    = 8;
   localparam logic [NW-1:0]   NC    = NW'(N);
   localparam int              P1W   = TERM_W + G_W;
   localparam int              P2W   = TERM_W + RW;
   localparam int              BKW   = TERM_W + NW;

   logic [P1W-1:0]    prod1;
   logic [P2W-1:0]    prod2;
   logic [BKW-1:0]    back;
   logic [BKW-1:0]    rem;
   logic [TERM_W-1:0] fixed;

   logic [TERM_W-1:0] p1_ff, p1_in;
   logic [G_W-1:0]    g1_ff, g2_ff, g3_ff;
   logic [TERM_W-1:0] sum1_ff, sum2_ff, sum3_ff, sum3_in;
   logic [TERM_W-1:0] q0_ff, q0_in;
   logic [TERM_W-1:0] p2_ff;
   logic [TERM_W-1:0] term_ff;

   // stage 1: product with g, drop the fraction
   always_comb begin
      prod1 = P1W'(src_term) * P1W'(src_g);
      p1_in = prod1[TERM_W+M_FRAC-1:M_FRAC];
   end

   // stage 2: quotient estimate by reciprocal
   always_comb begin
      prod2 = P2W'(p1_ff) * P2W'(RECIP);
      q0_in = prod2[RECIP_SHIFT+TERM_W-1:RECIP_SHIFT];
   end

   // stage 3: correct the estimate by one, accumulate
   always_comb begin
      back    = BKW'(q0_ff) * BKW'(NC);
      rem     = BKW'(p2_ff) - back;
      fixed   = q0_ff + TERM_W'(rem >= BKW'(NC));
      sum3_in = sum2_ff + fixed;
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      g1_ff   <= src_g;
      sum1_ff <= src_sum;
      q0_ff   <= q0_in;
      p2_ff   <= p1_ff;
      g2_ff   <= g1_ff;
      sum2_ff <= sum1_ff;
      term_ff <= fixed;
      sum3_ff <= sum3_in;
      g3_ff   <= g2_ff;
   end

   assign dst_g    = g3_ff;
   assign dst_term = term_ff;
   assign dst_sum  = sum3_ff;

endmodule

>>> rtl/bpe_place.sv
// ----------------------------------------------------------------------------
// Output scaler
// Scales an exact product by 2^(k - SCALE), rounds half away from zero,
// applies the sign and saturates to the payload range. Two stages.
// ----------------------------------------------------------------------------
module bpe_place
   import bpe_pkg::*;
#(
   parameter int DW    = BPE_DATA_WIDTH,
   parameter int PW    = 64,
   parameter int SCALE = 0
) (
   input  logic                 clock,
   input  logic [PW-1:0]        prod,
   input  logic signed [K_W-1:0] k,
   input  logic                 neg,
   output logic [DW-1:0]        value,
   output logic                 over
);

   localparam int XW   = PW + DW;
   localparam int U_W  = 12;
   localparam int UB   = DW - 1 + SCALE;
   localparam logic [DW:0]   LIM_POS = {2'b00, {(DW-1){1'b1}}};
   localparam logic [DW:0]   LIM_NEG = {2'b01, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

   logic signed [U_W-1:0] u;
   logic [XW-1:0]         x;
   logic [XW-1:0]         z;
   logic [DW+1:0]         rnd;
   logic [DW:0]           mag;
   logic [DW:0]           lim;
   logic                  over_all;

   logic [DW:0]   zl_ff;
   logic          pre_ff, pre_in;
   logic          neg_ff;
   logic [DW-1:0] value_ff, value_in;
   logic          over_ff;

   // stage 1: shift right by u (product pre-shifted up by DW)
   always_comb begin
      u      = U_W'(UB) - U_W'(k);
      x      = {prod, {DW{1'b0}}};
      z      = x >> u[U_W-2:0];
      pre_in = (prod != '0) && (u[U_W-1] || ((z >> (DW + 1)) != '0));
   end

   // stage 2: round, sign and saturate
   always_comb begin
      rnd      = {1'b0, zl_ff} + (DW+2)'(1);
      mag      = rnd[DW+1:1];
      lim      = neg_ff ? LIM_NEG : LIM_POS;
      over_all = pre_ff || (mag > lim);
      if (over_all) begin
         value_in = neg_ff ? SAT_NEG : SAT_POS;
      end else if (neg_ff) begin
         value_in = DW'(-mag);
      end else begin
         value_in = mag[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      zl_ff    <= z[DW:0];
      pre_ff   <= pre_in;
      neg_ff   <= neg;
      value_ff <= value_in;
      over_ff  <= over_all;
   end

   assign value = value_ff;
   assign over  = over_ff;

endmodule

>>> rtl/binding_potential_eval_core.sv
// ----------------------------------------------------------------------------
// Binding potential evaluator
// Universal binding energy curve: U = -A*B*(B+d)*exp(-d/B), its slope and
// its curvature, for d = x - l0, in saturating fixed point.
//
//   channel   ports                          transfer
//   request   start, busy, req_separation    start && !busy
//   response  rsp_valid, rsp_*               rsp_valid, one cycle
//   config    psel .. pready (APB style)     psel && penable && pwrite
//
// One transaction enters every cycle; busy stays low. Each result passes
// through 1 entry stage, 35 divider cells (one quotient bit each), 4 exponent
// stages, 12 series cells of 3 stages, 1 product setup stage, 2 wide
// multiplier stages, 2 scaler stages and the output register.
// Synchronous reset clears the valid pipe and loads the register defaults.
// The receiver takes every result on its strobe cycle; nothing stalls.
// ----------------------------------------------------------------------------
module binding_potential_eval_core
   import bpe_pkg::*;
#(
   parameter int DATA_WIDTH = BPE_DATA_WIDTH,
   parameter int FRAC_BITS  = BPE_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-1:0] req_separation,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_energy,
   output logic [DATA_WIDTH-1:0] rsp_slope,
   output logic [DATA_WIDTH-1:0] rsp_curvature,
   output logic                  rsp_fault,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready
);

   localparam int DW        = DATA_WIDTH;
   localparam int T_Q       = 1 + Q_BITS;
   localparam int T_YP      = T_Q + 2;
   localparam int T_KF      = T_YP + 1;
   localparam int T_G       = T_KF + 1;
   localparam int T_M       = T_G + 3 * TAYLOR_TERMS;
   localparam int T_PROD_IN = T_M + 1;
   localparam int T_PROD    = T_PROD_IN + 2;
   localparam int T_PLACE   = T_PROD + 2;
   localparam int T_OUT     = T_PLACE + 1;
   localparam int YP_W      = Q_BITS + LOG2E_W - S_FRAC;
   localparam int AM_W      = DW + TERM_W;
   localparam int BB_W      = 2 * DW;
   localparam int OMS_W     = Q_BITS + 1;
   localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic                 dneg;
      logic [DW:0]          dmag;
      logic                 bdneg;
      logic [DW:0]          bdmag;
      logic                 ovf;
      logic [Q_BITS-1:0]    q;
      logic signed [K_W-1:0] k;
      logic                 omsneg;
   } side_type;

   // configuration registers
   logic [DW-1:0] depth_ff, depth_in;
   logic [DW-2:0] decay_ff, decay_in;
   logic [DW-1:0] rest_ff, rest_in;
   logic          aneg;
   logic [DW-1:0] amag;
   logic          csr_write;

   // entry stage
   logic          accept;
   logic [DW:0]   d_w;
   logic [DW+1:0] bd_w;

   // sideband line and valid pipe
   side_type         line_ff [T_PLACE];
   side_type         line_in [T_PLACE];
   logic [T_OUT-1:0] vld_ff, vld_in;

   // divider chain
   logic [DW-2:0]     rem_w  [Q_BITS+1];
   logic [Q_BITS-1:0] quot_w [Q_BITS+1];

   // exponent stages
   logic [2*MUL_CHUNK-1:0]  yp_p;
   logic [YP_W-1:0]         yp;
   logic signed [K_W-1:0]   k_ff, k_in;
   logic [S_FRAC-1:0]       f_ff, f_in;
   logic [S_FRAC+LN2_W-1:0] gprod;
   logic [G_W-1:0]          g_ff;

   // series chain
   logic [G_W-1:0]    g_w    [TAYLOR_TERMS+1];
   logic [TERM_W-1:0] term_w [TAYLOR_TERMS+1];
   logic [TERM_W-1:0] sum_w  [TAYLOR_TERMS+1];

   // products
   logic [AM_W-1:0]       am_ff, am_in;
   logic [BB_W-1:0]       bb_ff, bb_in;
   logic signed [OMS_W:0] s_w, oms_w;
   logic [OMS_W-1:0]      oms_ff, oms_in;
   logic                  omsneg_ff;
   logic [AM_W+BB_W-1:0]  e_prod;
   logic [AM_W+DW:0]      s_prod;
   logic [AM_W+OMS_W-1:0] c_prod;

   // scalers and output
   logic [DW-1:0] e_val, s_val, c_val;
   logic          e_over, s_over, c_over;
   side_type      fin;
   logic          pos_big, neg_big;
   logic [DW-1:0] energy_ff, energy_in;
   logic [DW-1:0] slope_ff, slope_in;
   logic [DW-1:0] curv_ff, curv_in;
   logic          fault_ff, fault_in;

   // configuration write and read
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      depth_in = depth_ff;
      decay_in = decay_ff;
      rest_in  = rest_ff;
      if (csr_write) begin
         case (paddr[CSR_ADDR_W-1:2])
            REG_DEPTH_SCALE:     depth_in = pwdata;
            REG_DECAY_LENGTH:    decay_in = pwdata[DW-2:0];
            REG_REST_SEPARATION: rest_in  = pwdata;
            default:             ;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_ADDR_W-1:2])
         REG_DEPTH_SCALE:     prdata = depth_ff;
         REG_DECAY_LENGTH:    prdata = {1'b0, decay_ff};
         REG_REST_SEPARATION: prdata = rest_ff;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DW'(1) << FRAC_BITS;
         decay_ff <= (DW-1)'(1) << FRAC_BITS;
         rest_ff  <= '0;
      end else begin
         depth_ff <= depth_in;
         decay_ff <= decay_in;
         rest_ff  <= rest_in;
      end
   end

   assign aneg = depth_ff[DW-1];
   assign amag = aneg ? DW'(-depth_ff) : depth_ff;

   // accept every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // entry: offset from rest and offset plus decay length
   always_comb begin
      d_w  = {req_separation[DW-1], req_separation} - {rest_ff[DW-1], rest_ff};
      bd_w = {2'b00, decay_ff} + {d_w[DW], d_w};
   end

   // advance the sideband line, inserting fields as they are produced
   always_comb begin
      for (int j = 0; j < T_PLACE; j++) begin
         if (j == 0) begin
            line_in[j]        = '0;
            line_in[j].dneg   = d_w[DW];
            line_in[j].dmag   = d_w[DW] ? (DW+1)'(-d_w) : d_w;
            line_in[j].bdneg  = bd_w[DW+1];
            line_in[j].bdmag  = bd_w[DW+1] ? (DW+1)'(-bd_w) : bd_w[DW:0];
            line_in[j].ovf    = (line_in[j].dmag >> LIMIT_LOG2) >= {2'b00, decay_ff};
         end else begin
            line_in[j] = line_ff[j-1];
         end
         if (j == T_Q) begin
            line_in[j].q = quot_w[Q_BITS];
         end
         if (j == T_KF) begin
            line_in[j].k = k_ff;
         end
         if (j == T_PROD_IN) begin
            line_in[j].omsneg = omsneg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

   // track valid transactions
   assign vld_in = {vld_ff[T_OUT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ratio divider: one quotient bit per cell
   assign rem_w[0]  = (DW-1)'(line_ff[0].dmag >> LIMIT_LOG2);
   assign quot_w[0] = '0;

   generate
      for (genvar c = 0; c < Q_BITS; c++) begin : g_div
         bpe_div_cell #(
            .DW  (DW),
            .IDX (Q_BITS - 1 - c)
         ) u_cell (
            .clock        (clock),
            .divisor      (decay_ff),
            .dividend_mag (line_ff[c].dmag),
            .src_rem      (rem_w[c]),
            .src_quot     (quot_w[c]),
            .dst_rem      (rem_w[c+1]),
            .dst_quot     (quot_w[c+1])
         );
      end
   endgenerate

   // exponent in base 2: y = s * log2(e)
   bpe_wide_mul #(
      .AW (Q_BITS),
      .BW (LOG2E_W)
   ) u_log2e (
      .clock (clock),
      .src_a (quot_w[Q_BITS]),
      .src_b (LOG2E_Q28),
      .dst_p (yp_p)
   );

   assign yp = yp_p[YP_W+S_FRAC-1:S_FRAC];

   // split into integer k and fraction f, negate for positive offsets
   always_comb begin
      k_in = K_W'(yp[YP_W-1:S_FRAC]);
      f_in = yp[S_FRAC-1:0];
      if (!line_ff[T_YP-1].dneg && (yp != '0)) begin
         if (f_in != '0) begin
            k_in = -K_W'(yp[YP_W-1:S_FRAC]) - K_W'(1);
            f_in = S_FRAC'((S_FRAC+1)'(1) << S_FRAC) - yp[S_FRAC-1:0];
         end else begin
            k_in = -K_W'(yp[YP_W-1:S_FRAC]);
         end
      end
   end

   assign gprod = (S_FRAC+LN2_W)'(f_ff) * (S_FRAC+LN2_W)'(LN2_Q30);

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      f_ff <= f_in;
      g_ff <= gprod[S_FRAC+G_W-1:S_FRAC];
   end

   // exponential series chain
   assign g_w[0]    = g_ff;
   assign term_w[0] = TERM_W'(1) << M_FRAC;
   assign sum_w[0]  = TERM_W'(1) << M_FRAC;

   generate
      for (genvar n = 0; n < TAYLOR_TERMS; n++) begin : g_series
         bpe_taylor_cell #(
            .N (n + 1)
         ) u_cell (
            .clock    (clock),
            .src_g    (g_w[n]),
            .src_term (term_w[n]),
            .src_sum  (sum_w[n]),
            .dst_g    (g_w[n+1]),
            .dst_term (term_w[n+1]),
            .dst_sum  (sum_w[n+1])
         );
      end
   endgenerate

   // product setup: A*m, B*|B+d| and |1-s|
   always_comb begin
      am_in = AM_W'(amag) * AM_W'(sum_w[TAYLOR_TERMS]);
      bb_in = BB_W'(decay_ff) * BB_W'(line_ff[T_M-1].bdmag);
      s_w   = (OMS_W+1)'(line_ff[T_M-1].q);
      if (line_ff[T_M-1].dneg) begin
         s_w = -s_w;
      end
      oms_w  = ((OMS_W+1)'(1) << S_FRAC) - s_w;
      oms_in = oms_w[OMS_W] ? OMS_W'(-oms_w) : oms_w[OMS_W-1:0];
   end

   always_ff @(posedge clock) begin
      am_ff     <= am_in;
      bb_ff     <= bb_in;
      oms_ff    <= oms_in;
      omsneg_ff <= oms_w[OMS_W];
   end

   bpe_wide_mul #(
      .AW (AM_W),
      .BW (BB_W)
   ) u_mul_energy (
      .clock (clock),
      .src_a (am_ff),
      .src_b (bb_ff),
      .dst_p (e_prod)
   );

   bpe_wide_mul #(
      .AW (AM_W),
      .BW (DW + 1)
   ) u_mul_slope (
      .clock (clock),
      .src_a (am_ff),
      .src_b (line_ff[T_PROD_IN-1].dmag),
      .dst_p (s_prod)
   );

   bpe_wide_mul #(
      .AW (AM_W),
      .BW (OMS_W)
   ) u_mul_curv (
      .clock (clock),
      .src_a (am_ff),
      .src_b (oms_ff),
      .dst_p (c_prod)
   );

   // scale, round and saturate each value
   bpe_place #(
      .DW    (DW),
      .PW    (AM_W + BB_W),
      .SCALE (M_FRAC + 2 * FRAC_BITS)
   ) u_place_energy (
      .clock (clock),
      .prod  (e_prod),
      .k     (line_ff[T_PROD-1].k),
      .neg   (aneg == line_ff[T_PROD-1].bdneg),
      .value (e_val),
      .over  (e_over)
   );

   bpe_place #(
      .DW    (DW),
      .PW    (AM_W + DW + 1),
      .SCALE (M_FRAC + FRAC_BITS)
   ) u_place_slope (
      .clock (clock),
      .prod  (s_prod),
      .k     (line_ff[T_PROD-1].k),
      .neg   (aneg != line_ff[T_PROD-1].dneg),
      .value (s_val),
      .over  (s_over)
   );

   bpe_place #(
      .DW    (DW),
      .PW    (AM_W + OMS_W),
      .SCALE (M_FRAC + S_FRAC)
   ) u_place_curv (
      .clock (clock),
      .prod  (c_prod),
      .k     (line_ff[T_PROD-1].k),
      .neg   (aneg != line_ff[T_PROD-1].omsneg),
      .value (c_val),
      .over  (c_over)
   );

   // select special cases and register the result
   always_comb begin
      fin     = line_ff[T_PLACE-1];
      pos_big = !fin.dneg && fin.ovf;
      neg_big = fin.dneg && (fin.ovf || fin.q[Q_BITS-1]);
      energy_in = '0;
      slope_in  = '0;
      curv_in   = '0;
      fault_in  = 1'b0;
      if (decay_ff == '0) begin
         fault_in = 1'b1;
      end else if (amag == '0) begin
         fault_in = 1'b0;
      end else if (pos_big) begin
         fault_in = 1'b0;
      end else if (neg_big) begin
         energy_in = aneg ? SAT_NEG : SAT_POS;
         slope_in  = aneg ? SAT_POS : SAT_NEG;
         curv_in   = aneg ? SAT_NEG : SAT_POS;
         fault_in  = 1'b1;
      end else begin
         energy_in = e_val;
         slope_in  = s_val;
         curv_in   = c_val;
         fault_in  = e_over || s_over || c_over;
      end
   end

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      slope_ff  <= slope_in;
      curv_ff   <= curv_in;
      fault_ff  <= fault_in;
   end

   assign rsp_valid     = vld_ff[T_OUT-1];
   assign rsp_energy    = energy_ff;
   assign rsp_slope     = slope_ff;
   assign rsp_curvature = curv_ff;
   assign rsp_fault     = fault_ff;

endmodule

>>> sim/binding_potential_eval_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binding potential evaluator checker
// Tracks the register writes, predicts energy, slope, curvature and fault for
// every accepted request and compares each response against the oldest
// prediction.
// ----------------------------------------------------------------------------
module binding_potential_eval_checker
   import bpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_separation,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_energy,
   input  logic [31:0] rsp_slope,
   input  logic [31:0] rsp_curvature,
   input  logic        rsp_fault,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          error_count,
   output int          pending_count,
   output int          checked_count
);

   typedef struct packed {
      logic [31:0] energy;
      logic [31:0] slope;
      logic [31:0] curvature;
      logic        fault;
   } potential_type;

   logic [31:0]   depth_scale;
   logic [30:0]   decay_length;
   logic [31:0]   rest_separation;
   potential_type expected_q[$];

   // scale p by 2^sh, round half away from zero, saturate; bit 32 flags overflow
   function automatic logic [32:0] place_q16(logic [127:0] p, int sh, bit neg);
      logic [63:0] lim;
      logic [63:0] mag;
      bit          over;
      int          r;
      lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      mag  = 64'd0;
      over = 1'b0;
      if (p == 128'd0) return 33'd0;
      if (sh >= 0) begin
         if (sh >= 64 || p[127:64] != 64'd0 || p[63:0] > (lim >> sh)) over = 1'b1;
         else mag = p[63:0] << sh;
      end else begin
         r = -sh;
         if (r < 128) begin
            p = p + (128'd1 << (r - 1));
            p = p >> r;
            if (p[127:64] != 64'd0 || p[63:0] > lim) over = 1'b1;
            else mag = p[63:0];
         end
      end
      if (over) mag = lim;
      mag = neg ? (64'd0 - mag) : mag;
      return {over, mag[31:0]};
   endfunction

   function automatic potential_type predict_potential(logic [31:0] x, logic [31:0] a,
                                                       logic [30:0] b, logic [31:0] l0);
      potential_type o;
      longint        av, d, bd, s, oms;
      logic [63:0]   amag, dmag, bb, q, yp, f, g, term, m, bdmag, omsmag;
      bit            aneg, dneg;
      int            k;
      logic [32:0]   r0, r1, r2;
      o = '0;
      if (b == 31'd0) begin
         o.fault = 1'b1;
         return o;
      end
      av   = longint'($signed(a));
      aneg = av < 0;
      amag = aneg ? -av : av;
      if (amag == 64'd0) return o;
      d    = longint'($signed(x)) - longint'($signed(l0));
      dneg = d < 0;
      dmag = dneg ? -d : d;
      bb   = {33'd0, b};
      q    = (dmag << S_FRAC) / bb;
      // exponential underflow far above rest
      if (!dneg && q >= (64'd1 << (S_FRAC + LIMIT_LOG2))) return o;
      // overflow far below rest
      if (dneg && q >= (64'd1 << (S_FRAC + LIMIT_LOG2 - 1))) begin
         o.energy    = aneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         o.slope     = aneg ? 32'h7FFF_FFFF : 32'h8000_0000;
         o.curvature = o.energy;
         o.fault     = 1'b1;
         return o;
      end
      // split -s*log2(e) into integer exponent and fraction
      yp = 64'((128'(q) * 128'(LOG2E_Q28)) >> S_FRAC);
      f  = yp & ((64'd1 << S_FRAC) - 1);
      k  = int'(yp >> S_FRAC);
      if (!dneg && yp != 64'd0) begin
         k = -k;
         if (f != 64'd0) begin
            k = k - 1;
            f = (64'd1 << S_FRAC) - f;
         end
      end
      g    = (f * 64'(LN2_Q30)) >> S_FRAC;
      term = 64'd1 << M_FRAC;
      m    = term;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = ((term * g) >> M_FRAC) / n;
         m    = m + term;
      end
      bd     = longint'(bb) + d;
      bdmag  = bd < 0 ? -bd : bd;
      s      = dneg ? -longint'(q) : longint'(q);
      oms    = (longint'(1) << S_FRAC) - s;
      omsmag = oms < 0 ? -oms : oms;
      r0 = place_q16(128'(amag) * 128'(bb) * 128'(bdmag) * 128'(m),
                     k - M_FRAC - 2 * BPE_FRAC_BITS, aneg == (bd < 0));
      r1 = place_q16(128'(amag) * 128'(dmag) * 128'(m),
                     k - M_FRAC - BPE_FRAC_BITS, aneg != dneg);
      r2 = place_q16(128'(amag) * 128'(omsmag) * 128'(m),
                     k - M_FRAC - S_FRAC, aneg != (oms < 0));
      o.energy    = r0[31:0];
      o.slope     = r1[31:0];
      o.curvature = r2[31:0];
      o.fault     = r0[32] | r1[32] | r2[32];
      return o;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      potential_type want;
      if (reset) begin
         depth_scale     <= 32'h0001_0000;
         decay_length    <= 31'h0001_0000;
         rest_separation <= 32'd0;
         expected_q.delete();
         error_count     <= 0;
         checked_count   <= 0;
      end else begin
         // track register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_DEPTH_SCALE:     depth_scale     <= pwdata;
               REG_DECAY_LENGTH:    decay_length    <= pwdata[30:0];
               REG_REST_SEPARATION: rest_separation <= pwdata;
               default: ;
            endcase
         end
         // predict on each accepted request
         if (start && !busy)
            expected_q.push_back(predict_potential(req_separation, depth_scale,
                                                   decay_length, rest_separation));
         // compare each response against the oldest prediction
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               if (error_count < 10)
                  $display("checker: response with nothing expected at %0t", $realtime);
               error_count <= error_count + 1;
            end else begin
               want = expected_q.pop_front();
               checked_count <= checked_count + 1;
               if (want.energy !== rsp_energy || want.slope !== rsp_slope ||
                   want.curvature !== rsp_curvature || want.fault !== rsp_fault) begin
                  if (error_count < 10)
                     $display("checker: mismatch exp %h %h %h %b got %h %h %h %b",
                              want.energy, want.slope, want.curvature, want.fault,
                              rsp_energy, rsp_slope, rsp_curvature, rsp_fault);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> sim/binding_potential_eval_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binding potential evaluator testbench
// Drives directed and random separations through several register settings,
// with random request gaps; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module binding_potential_eval_core_tb;
   import bpe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start;
   logic        busy;
   logic [31:0] req_separation;
   logic        rsp_valid;
   logic [31:0] rsp_energy, rsp_slope, rsp_curvature;
   logic        rsp_fault;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;
   int          error_count, pending_count, checked_count;
   int          cycle_count = 0;
   int          sent_count = 0;
   bit          no_idle;

   always #1 clock = ~clock;

   binding_potential_eval_core u_top (
      .clock, .reset, .start, .busy, .req_separation,
      .rsp_valid, .rsp_energy, .rsp_slope, .rsp_curvature, .rsp_fault,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   binding_potential_eval_checker u_checker (
      .clock, .reset, .start, .busy, .req_separation,
      .rsp_valid, .rsp_energy, .rsp_slope, .rsp_curvature, .rsp_fault,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .error_count, .pending_count, .checked_count
   );

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_separation(logic [31:0] x);
      int pick, gap;
      start          <= 1'b1;
      req_separation <= x;
      do @(posedge clock); while (busy);
      sent_count++;
      // mostly no idle, sometimes briefly, rarely long
      pick = $urandom_range(0, 9);
      gap  = no_idle ? 0 : (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // hold until every response is back, then let the pipe settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] a, logic [31:0] b, logic [31:0] l0);
      csr_write(REG_DEPTH_SCALE, a);
      csr_write(REG_DECAY_LENGTH, b);
      csr_write(REG_REST_SEPARATION, l0);
   endtask

   // separations: near rest in units of B, tiny offsets, or anything
   task automatic random_separations(int count, logic [31:0] b, logic [31:0] l0);
      longint span;
      int     pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 3);
         span = (longint'(b[30:0]) * (longint'($urandom_range(0, 2600)) - 1000)) >>> 4;
         case (pick)
            0, 1:    send_separation(32'(longint'($signed(l0)) + span));
            2:       send_separation(l0 + 32'($urandom_range(0, 511)) - 32'd256);
            default: send_separation($urandom);
         endcase
      end
   endtask

   initial begin
      logic [31:0] a, b, l0;
      start          <= 1'b0;
      req_separation <= 32'd0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= 4'd0;
      pwdata         <= 32'd0;
      no_idle        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default registers, field extremes, both saturation ends
      send_separation(32'h8000_0000);
      send_separation(32'h7FFF_FFFF);
      send_separation(32'h0000_0000);
      send_separation(32'h0000_0001);
      send_separation(32'hFFFF_FFFF);
      send_separation(32'h0001_0000);
      send_separation(32'hFFFF_0000);
      send_separation(32'h0080_0000);
      send_separation(32'h007F_FFFF);
      send_separation(32'hFFC0_0000);
      send_separation(32'hFFC0_0001);
      send_separation(32'h0002_0000);
      send_separation(32'hFFF0_0000);
      send_separation(32'h0000_8000);
      drain();

      // fixed extremes first, random settings afterwards
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: begin a = 32'd0;          b = 32'h0001_0000; l0 = 32'd0;          end
            1: begin a = 32'h0001_0000;  b = 32'd0;         l0 = 32'd0;          end
            2: begin a = 32'h7FFF_FFFF;  b = 32'h7FFF_FFFF; l0 = 32'h7FFF_FFFF;  end
            3: begin a = 32'h8000_0000;  b = 32'h0000_0001; l0 = 32'h8000_0000;  end
            4: begin a = 32'h8000_0000;  b = 32'hFFFF_FFFF; l0 = 32'd0;          end
            5: begin a = 32'hFFFF_0000;  b = 32'h0000_8000; l0 = 32'h0001_8000;  end
            default: begin
               a  = $urandom;
               b  = {1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ?
                     31'($urandom) : 31'($urandom_range(1, 1 << 20))};
               l0 = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            end
         endcase
         no_idle = (phase % 3 == 0);
         configure(a, b, l0);
         @(posedge clock);
         random_separations(55, {1'b0, b[30:0]}, l0);
         drain();
      end

      $display("tb: %0d separations sent, %0d responses checked over 12 register settings",
               sent_count, checked_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
